// File: rtl/hpmp_pkg.sv
// ----------------------------------------------------------------------------
// hpmp_pkg
// Shared types and constants of the heading PID motor power block.
// ----------------------------------------------------------------------------
package hpmp_pkg;

    localparam int WINDOW_DEF = 10;
    localparam int DATA_W     = 16;
    localparam int TOL_W      = 15;
    localparam int POWER_W    = 7;
    localparam int APB_W      = 32;
    localparam int ADDR_W     = 5;
    localparam int IDX_W      = 3;

    // register map, index of each register (byte address is 4 * index)
    localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
    localparam logic [IDX_W-1:0] REG_PROP   = 3'd1;
    localparam logic [IDX_W-1:0] REG_INTEG  = 3'd2;
    localparam logic [IDX_W-1:0] REG_DERIV  = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOL    = 3'd4;

    localparam logic signed [DATA_W-1:0] TARGET_RST = 16'sd0;
    localparam logic signed [DATA_W-1:0] PROP_RST   = 16'sd256;
    localparam logic signed [DATA_W-1:0] INTEG_RST  = 16'sd0;
    localparam logic signed [DATA_W-1:0] DERIV_RST  = 16'sd0;
    localparam logic [TOL_W-1:0]         TOL_RST    = 15'd2;

    // speed clamp bounds in Q.8 units and the power mapping
    localparam int SPEED_MIN_Q8 = 18 * 256;
    localparam int SPEED_MAX_Q8 = 494 * 256;
    localparam int POWER_MAX    = 48;
    localparam int MAG_W        = 17;
    // power = floor(mag * 48 / SPEED_MAX_Q8) = floor(mag * 3 / 7904)
    localparam int POWER_SCALE  = 3;
    localparam int POWER_STEP   = SPEED_MAX_Q8 * POWER_SCALE / POWER_MAX;
    localparam int M3_W         = 19;
    localparam int PROD_W       = 2 * DATA_W;

    typedef struct packed {
        logic [DATA_W-1:0] target;
        logic [DATA_W-1:0] gain_prop;
        logic [DATA_W-1:0] gain_integ;
        logic [DATA_W-1:0] gain_deriv;
        logic [TOL_W-1:0]  tol;
    } t_cfg;

endpackage

// File: rtl/hpmp_regs.sv
// ----------------------------------------------------------------------------
// hpmp_regs
// APB configuration registers: setpoint, three gains and the error tolerance.
// ----------------------------------------------------------------------------
module hpmp_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [hpmp_pkg::ADDR_W-1:0]   paddr,
    input  logic [hpmp_pkg::APB_W-1:0]    pwdata,
    output logic [hpmp_pkg::APB_W-1:0]    prdata,
    output logic                          pready,
    output hpmp_pkg::t_cfg                o_cfg
);

    hpmp_pkg::t_cfg                r_cfg;
    logic [hpmp_pkg::IDX_W-1:0]    w_idx;
    logic                          w_wr;

    assign pready = 1'b1;
    assign w_idx  = paddr[hpmp_pkg::ADDR_W-1:2];
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target     <= hpmp_pkg::TARGET_RST;
            r_cfg.gain_prop  <= hpmp_pkg::PROP_RST;
            r_cfg.gain_integ <= hpmp_pkg::INTEG_RST;
            r_cfg.gain_deriv <= hpmp_pkg::DERIV_RST;
            r_cfg.tol        <= hpmp_pkg::TOL_RST;
        end else if (w_wr) begin
            case (w_idx)
                hpmp_pkg::REG_TARGET: begin
                    r_cfg.target <= pwdata[hpmp_pkg::DATA_W-1:0];
                end
                hpmp_pkg::REG_PROP: begin
                    r_cfg.gain_prop <= pwdata[hpmp_pkg::DATA_W-1:0];
                end
                hpmp_pkg::REG_INTEG: begin
                    r_cfg.gain_integ <= pwdata[hpmp_pkg::DATA_W-1:0];
                end
                hpmp_pkg::REG_DERIV: begin
                    r_cfg.gain_deriv <= pwdata[hpmp_pkg::DATA_W-1:0];
                end
                hpmp_pkg::REG_TOL: begin
                    r_cfg.tol <= pwdata[hpmp_pkg::TOL_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // sign-extend the 16-bit registers on readback
    always_comb begin
        case (w_idx)
            hpmp_pkg::REG_TARGET: prdata = hpmp_pkg::APB_W'($signed(r_cfg.target));
            hpmp_pkg::REG_PROP:   prdata = hpmp_pkg::APB_W'($signed(r_cfg.gain_prop));
            hpmp_pkg::REG_INTEG:  prdata = hpmp_pkg::APB_W'($signed(r_cfg.gain_integ));
            hpmp_pkg::REG_DERIV:  prdata = hpmp_pkg::APB_W'($signed(r_cfg.gain_deriv));
            hpmp_pkg::REG_TOL:    prdata = hpmp_pkg::APB_W'(r_cfg.tol);
            default:              prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/hpmp_window.sv
// ----------------------------------------------------------------------------
// hpmp_window
// Saturated heading error, error window shift line and its running sum.
// ----------------------------------------------------------------------------
module hpmp_window #(
    parameter int WINDOW = hpmp_pkg::WINDOW_DEF,
    parameter int SUM_W  = hpmp_pkg::DATA_W + $clog2(WINDOW)
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_accept,
    input  logic signed [hpmp_pkg::DATA_W-1:0] i_heading,
    input  logic signed [hpmp_pkg::DATA_W-1:0] i_turn_rate,
    input  hpmp_pkg::t_cfg                    i_cfg,
    output logic signed [hpmp_pkg::DATA_W-1:0] o_err,
    output logic signed [SUM_W-1:0]           o_sum,
    output logic signed [hpmp_pkg::DATA_W-1:0] o_rate,
    output logic                              o_quiet
);

    localparam int DW = hpmp_pkg::DATA_W;

    logic signed [DW-1:0]    r_win [WINDOW];
    logic signed [SUM_W-1:0] r_sum;
    logic signed [DW-1:0]    r_err;
    logic signed [DW-1:0]    r_rate;
    logic                    r_quiet;

    logic signed [DW:0]      w_diff;
    logic signed [DW-1:0]    n_err;
    logic [DW:0]             w_abs;
    logic signed [SUM_W:0]   w_sum_wide;
    logic signed [SUM_W-1:0] n_sum;

    always_comb begin
        w_diff = (DW+1)'($signed(i_cfg.target)) - (DW+1)'(i_heading);
        if (w_diff > (DW+1)'(32767)) begin
            n_err = 16'sh7FFF;
        end else if (w_diff < -(DW+1)'(32768)) begin
            n_err = 16'sh8000;
        end else begin
            n_err = w_diff[DW-1:0];
        end
        w_abs      = n_err[DW-1] ? -(DW+1)'(n_err) : (DW+1)'(n_err);
        w_sum_wide = (SUM_W+1)'(r_sum) - (SUM_W+1)'(r_win[WINDOW-1]) + (SUM_W+1)'(n_err);
        n_sum      = w_sum_wide[SUM_W-1:0];
    end

    // oldest error falls off the far end of the line
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < WINDOW; i++) begin
                r_win[i] <= '0;
            end
            r_sum <= '0;
        end else if (i_accept) begin
            r_win[0] <= n_err;
            for (int i = 1; i < WINDOW; i++) begin
                r_win[i] <= r_win[i-1];
            end
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_err   <= n_err;
            r_rate  <= i_turn_rate;
            r_quiet <= w_abs < (DW+1)'(i_cfg.tol);
        end
    end

    assign o_err   = r_err;
    assign o_sum   = r_sum;
    assign o_rate  = r_rate;
    assign o_quiet = r_quiet;

endmodule

// File: rtl/hpmp_gain.sv
// ----------------------------------------------------------------------------
// hpmp_gain
// Gain products in one stage, signed speed sum in the next.
// ----------------------------------------------------------------------------
module hpmp_gain #(
    parameter int SUM_W = hpmp_pkg::DATA_W + $clog2(hpmp_pkg::WINDOW_DEF),
    parameter int SPD_W = SUM_W + hpmp_pkg::DATA_W + 2
) (
    input  logic                              i_clk,
    input  logic                              i_en_prod,
    input  logic                              i_en_sum,
    input  hpmp_pkg::t_cfg                    i_cfg,
    input  logic signed [hpmp_pkg::DATA_W-1:0] i_err,
    input  logic signed [SUM_W-1:0]           i_sum,
    input  logic signed [hpmp_pkg::DATA_W-1:0] i_rate,
    input  logic                              i_quiet,
    output logic signed [SPD_W-1:0]           o_speed,
    output logic                              o_quiet
);

    localparam int PW = hpmp_pkg::PROD_W;
    localparam int IW = SUM_W + hpmp_pkg::DATA_W;

    logic signed [PW-1:0]    r_pp;
    logic signed [IW-1:0]    r_pi;
    logic signed [PW-1:0]    r_pd;
    logic                    r_quiet_p;
    logic signed [SPD_W-1:0] r_speed;
    logic                    r_quiet_s;

    always_ff @(posedge i_clk) begin
        if (i_en_prod) begin
            r_pp      <= $signed(i_cfg.gain_prop) * i_err;
            r_pi      <= IW'($signed(i_cfg.gain_integ)) * IW'(i_sum);
            r_pd      <= $signed(i_cfg.gain_deriv) * i_rate;
            r_quiet_p <= i_quiet;
        end
    end

    // proportional term enters negated
    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_speed   <= SPD_W'(r_pi) - SPD_W'(r_pp) + SPD_W'(r_pd);
            r_quiet_s <= r_quiet_p;
        end
    end

    assign o_speed = r_speed;
    assign o_quiet = r_quiet_s;

endmodule

// File: rtl/hpmp_power.sv
// ----------------------------------------------------------------------------
// hpmp_power
// Clamp of |speed|, scaling to motor power steps and sign restore.
// ----------------------------------------------------------------------------
module hpmp_power #(
    parameter int SPD_W = hpmp_pkg::DATA_W * 2 + 6
) (
    input  logic                               i_clk,
    input  logic                               i_en,
    input  logic signed [SPD_W-1:0]            i_speed,
    input  logic                               i_quiet,
    output logic signed [hpmp_pkg::POWER_W-1:0] o_power
);

    localparam int PMAX = hpmp_pkg::POWER_MAX;
    localparam int MW   = hpmp_pkg::MAG_W;
    localparam int M3W  = hpmp_pkg::M3_W;
    localparam int PWW  = hpmp_pkg::POWER_W;

    logic [SPD_W-1:0]            w_mag;
    logic [MW-1:0]               w_magc;
    logic [M3W-1:0]              w_m3;
    logic [PMAX-1:0]             w_thr;
    logic [PWW-1:0]              w_steps;
    logic signed [PWW-1:0]       n_power;
    logic signed [PWW-1:0]       r_power;

    always_comb begin
        w_mag = i_speed[SPD_W-1] ? -i_speed : i_speed;
        if (w_mag > SPD_W'(hpmp_pkg::SPEED_MAX_Q8)) begin
            w_magc = MW'(hpmp_pkg::SPEED_MAX_Q8);
        end else if (w_mag < SPD_W'(hpmp_pkg::SPEED_MIN_Q8)) begin
            w_magc = MW'(hpmp_pkg::SPEED_MIN_Q8);
        end else begin
            w_magc = w_mag[MW-1:0];
        end
        w_m3 = M3W'(w_magc) * M3W'(hpmp_pkg::POWER_SCALE);
        // thermometer of step boundaries, its population is the floor quotient
        for (int k = 0; k < PMAX; k++) begin
            w_thr[k] = w_m3 >= M3W'((k + 1) * hpmp_pkg::POWER_STEP);
        end
        w_steps = PWW'($countones(w_thr));
        if (w_steps == '0) begin
            w_steps = PWW'(1);
        end
        if (i_quiet || (i_speed == '0)) begin
            n_power = '0;
        end else if (i_speed[SPD_W-1]) begin
            n_power = -$signed(w_steps);
        end else begin
            n_power = $signed(w_steps);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_power <= n_power;
        end
    end

    assign o_power = r_power;

endmodule

// File: rtl/heading_pid_motor_power.sv
// ----------------------------------------------------------------------------
// heading_pid_motor_power
// Heading-hold PID loop: gyro sample in, signed motor power command out.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  ------    ---------  ---------------------  --------------------------
//  sample    in         i_in_valid/o_in_stall  i_heading, i_turn_rate
//  power     out        o_out_valid/i_out_stall o_motor_power
//  config    in         APB psel/penable       paddr, pwdata, prdata
//
//  One sample per cycle while the output is not stalled; each result passes
//  through the window stage, product stage, speed sum and power stage, in
//  that order, before it is valid at the output.
//  Reset is synchronous, active low; it clears the window, the running sum,
//  the stage valids and restores the register defaults. No clearing sweep.
//  Each stage moves when the one after it is empty or moving, so a stalled
//  output fills the pipeline before the sample side stalls.
//
module heading_pid_motor_power #(
    parameter int WINDOW = hpmp_pkg::WINDOW_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic signed [hpmp_pkg::DATA_W-1:0]  i_heading,
    input  logic signed [hpmp_pkg::DATA_W-1:0]  i_turn_rate,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic signed [hpmp_pkg::POWER_W-1:0] o_motor_power,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [hpmp_pkg::ADDR_W-1:0]         paddr,
    input  logic [hpmp_pkg::APB_W-1:0]          pwdata,
    output logic [hpmp_pkg::APB_W-1:0]          prdata,
    output logic                                pready
);

    // window sum needs log2(WINDOW) bits over the error width
    localparam int SUM_W = hpmp_pkg::DATA_W + $clog2(WINDOW);
    localparam int SPD_W = SUM_W + hpmp_pkg::DATA_W + 2;

    hpmp_pkg::t_cfg                    w_cfg;
    logic signed [hpmp_pkg::DATA_W-1:0] w_err;
    logic signed [SUM_W-1:0]           w_sum;
    logic signed [hpmp_pkg::DATA_W-1:0] w_rate;
    logic                              w_quiet_win;
    logic signed [SPD_W-1:0]           w_speed;
    logic                              w_quiet_spd;

    logic r_v_win, r_v_prod, r_v_sum, r_v_out;
    logic w_en_win, w_en_prod, w_en_sum, w_en_out;
    logic w_accept;

    // stage enables: load when empty or when the downstream stage advances
    assign w_en_out  = !r_v_out  || !i_out_stall;
    assign w_en_sum  = !r_v_sum  || w_en_out;
    assign w_en_prod = !r_v_prod || w_en_sum;
    assign w_en_win  = !r_v_win  || w_en_prod;

    assign o_in_stall = !w_en_win;
    assign w_accept   = i_in_valid && w_en_win;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v_win  <= 1'b0;
            r_v_prod <= 1'b0;
            r_v_sum  <= 1'b0;
            r_v_out  <= 1'b0;
        end else begin
            if (w_en_win) begin
                r_v_win <= i_in_valid;
            end
            if (w_en_prod) begin
                r_v_prod <= r_v_win;
            end
            if (w_en_sum) begin
                r_v_sum <= r_v_prod;
            end
            if (w_en_out) begin
                r_v_out <= r_v_sum;
            end
        end
    end

    hpmp_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    // window state advances only on an accepted transaction
    hpmp_window #(
        .WINDOW (WINDOW),
        .SUM_W  (SUM_W)
    ) u_window (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_heading   (i_heading),
        .i_turn_rate (i_turn_rate),
        .i_cfg       (w_cfg),
        .o_err       (w_err),
        .o_sum       (w_sum),
        .o_rate      (w_rate),
        .o_quiet     (w_quiet_win)
    );

    hpmp_gain #(
        .SUM_W (SUM_W),
        .SPD_W (SPD_W)
    ) u_gain (
        .i_clk     (i_clk),
        .i_en_prod (w_en_prod),
        .i_en_sum  (w_en_sum),
        .i_cfg     (w_cfg),
        .i_err     (w_err),
        .i_sum     (w_sum),
        .i_rate    (w_rate),
        .i_quiet   (w_quiet_win),
        .o_speed   (w_speed),
        .o_quiet   (w_quiet_spd)
    );

    hpmp_power #(
        .SPD_W (SPD_W)
    ) u_power (
        .i_clk   (i_clk),
        .i_en    (w_en_out),
        .i_speed (w_speed),
        .i_quiet (w_quiet_spd),
        .o_power (o_motor_power)
    );

    assign o_out_valid = r_v_out;

`ifndef SYNTHESIS
    // sample side stalls only when every stage is full and the output is held
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_v_win && r_v_prod && r_v_sum && o_out_valid && i_out_stall))
        else $error("input stalled with a free pipeline slot");

    a_power_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_motor_power <= 7'sd48) && (o_motor_power >= -7'sd48)))
        else $error("motor power out of range");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("pipeline not empty after reset");
`endif

endmodule

// File: sim/heading_pid_motor_power_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_motor_power_chk
// Predicts each motor power command from the gyro samples the block takes
// and compares it with the command that comes out.
// ----------------------------------------------------------------------------
module heading_pid_motor_power_chk (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_stall,
    input  logic signed [hpmp_pkg::DATA_W-1:0]  i_heading,
    input  logic signed [hpmp_pkg::DATA_W-1:0]  i_turn_rate,
    input  logic                                i_out_valid,
    input  logic                                i_out_stall,
    input  logic signed [hpmp_pkg::POWER_W-1:0] i_motor_power,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic                                i_pready,
    input  logic [hpmp_pkg::ADDR_W-1:0]         i_paddr,
    input  logic [hpmp_pkg::APB_W-1:0]          i_pwdata,
    output int                                  o_errors,
    output int                                  o_pending
);
    import hpmp_pkg::*;

    localparam int ERR_MAX     = 2 ** (DATA_W - 1) - 1;
    localparam int ERR_MIN     = -(2 ** (DATA_W - 1));
    localparam int POWER_FLOOR = 1;

    logic signed [DATA_W-1:0]  target_r;
    logic signed [DATA_W-1:0]  prop_r;
    logic signed [DATA_W-1:0]  integ_r;
    logic signed [DATA_W-1:0]  deriv_r;
    logic [TOL_W-1:0]          tol_r;

    logic signed [DATA_W-1:0]  err_ring [WINDOW_DEF];
    int                        ring_pos;
    int                        ring_sum;
    logic signed [POWER_W-1:0] pending_power [$];
    int                        mismatch_count = 0;

    // Q.8 speed from the three terms, then deadband, clamp and scale to power
    function automatic logic signed [POWER_W-1:0] motor_power_for(input int err, input int rate);
        longint speed;
        longint mag;
        longint pwr;
        int     abs_err;
        speed = -longint'(prop_r) * err + longint'(integ_r) * ring_sum
              + longint'(deriv_r) * rate;
        abs_err = (err < 0) ? -err : err;
        if (abs_err < int'(tol_r) || speed == 0) begin
            return '0;
        end
        mag = (speed < 0) ? -speed : speed;
        if (mag > SPEED_MAX_Q8) mag = SPEED_MAX_Q8;
        if (mag < SPEED_MIN_Q8) mag = SPEED_MIN_Q8;
        pwr = mag * POWER_MAX / SPEED_MAX_Q8;
        if (pwr < POWER_FLOOR) pwr = POWER_FLOOR;
        if (speed < 0) pwr = -pwr;
        return POWER_W'(pwr);
    endfunction

    // saturate the error, roll it into the window, queue the command it yields
    task automatic absorb_sample(input logic signed [DATA_W-1:0] heading,
                                 input logic signed [DATA_W-1:0] rate);
        int err;
        err = int'(target_r) - int'(heading);
        if (err > ERR_MAX) err = ERR_MAX;
        if (err < ERR_MIN) err = ERR_MIN;
        ring_sum = ring_sum - int'(err_ring[ring_pos]) + err;
        err_ring[ring_pos] = DATA_W'(err);
        ring_pos = (ring_pos + 1 >= WINDOW_DEF) ? 0 : ring_pos + 1;
        pending_power.push_back(motor_power_for(err, int'(rate)));
    endtask

    always @(posedge i_clk) begin : watch
        logic signed [POWER_W-1:0] want;
        int                        k;
        if (!i_rst_n) begin
            target_r = TARGET_RST;
            prop_r   = PROP_RST;
            integ_r  = INTEG_RST;
            deriv_r  = DERIV_RST;
            tol_r    = TOL_RST;
            for (k = 0; k < WINDOW_DEF; k++) err_ring[k] = '0;
            ring_pos = 0;
            ring_sum = 0;
            pending_power.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_power.size() == 0) begin
                    $display("%0t: motor power %0d arrived with nothing expected",
                             $time, i_motor_power);
                    mismatch_count++;
                end else begin
                    want = pending_power.pop_front();
                    if (i_motor_power !== want) begin
                        $display("%0t: motor power expected %0d, got %0d",
                                 $time, want, i_motor_power);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                absorb_sample(i_heading, i_turn_rate);
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[2 +: IDX_W])
                    REG_TARGET: target_r = i_pwdata[DATA_W-1:0];
                    REG_PROP:   prop_r   = i_pwdata[DATA_W-1:0];
                    REG_INTEG:  integ_r  = i_pwdata[DATA_W-1:0];
                    REG_DERIV:  deriv_r  = i_pwdata[DATA_W-1:0];
                    REG_TOL:    tol_r    = i_pwdata[TOL_W-1:0];
                    default:    ;
                endcase
            end
        end
        o_errors  <= mismatch_count;
        o_pending <= pending_power.size();
    end

endmodule

// File: sim/heading_pid_motor_power_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heading_pid_motor_power_tb
// Drives gyro samples and register writes into the heading PID block under
// several idling patterns; the checker beside it predicts every command.
// ----------------------------------------------------------------------------
module heading_pid_motor_power_tb;
    import hpmp_pkg::*;

    // longest quiet stretch a correct run can show is the receiver hold-off
    // plus a few sender gaps; take it many times over
    localparam int WATCHDOG_LIMIT = 4000;
    // pipeline is four stages deep; give it a little more before any write
    localparam int DRAIN_CYCLES   = 8;
    localparam int PHASE_ITEMS    = 206;
    localparam int PHASE_COUNT    = 8;
    localparam int HOLD_OFF       = 150;

    localparam logic signed [DATA_W-1:0] S16_MIN = 16'sh8000;
    localparam logic signed [DATA_W-1:0] S16_MAX = 16'sh7fff;
    localparam logic [TOL_W-1:0]         TOL_MAX = 15'h7fff;

    logic                         i_clk;
    logic                         i_rst_n       = 1'b0;
    logic                         i_in_valid    = 1'b0;
    logic                         o_in_stall;
    logic signed [DATA_W-1:0]     i_heading     = '0;
    logic signed [DATA_W-1:0]     i_turn_rate   = '0;
    logic                         o_out_valid;
    logic                         i_out_stall   = 1'b0;
    logic signed [POWER_W-1:0]    o_motor_power;
    logic                         psel          = 1'b0;
    logic                         penable       = 1'b0;
    logic                         pwrite        = 1'b0;
    logic [ADDR_W-1:0]            paddr         = '0;
    logic [APB_W-1:0]             pwdata        = '0;
    logic [APB_W-1:0]             prdata;
    logic                         pready;

    int                           mismatches;
    int                           commands_owed;
    int                           idle_pct      = 0;
    int                           stall_pct     = 0;
    int                           hold_cycles   = 0;
    logic signed [DATA_W-1:0]     cur_target    = '0;

    heading_pid_motor_power #(
        .WINDOW (WINDOW_DEF)
    ) i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_heading     (i_heading),
        .i_turn_rate   (i_turn_rate),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_motor_power (o_motor_power),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    heading_pid_motor_power_chk i_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_heading     (i_heading),
        .i_turn_rate   (i_turn_rate),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_motor_power (o_motor_power),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_errors      (mismatches),
        .o_pending     (commands_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: hold off for a long stretch when asked, else stall at random.
    initial begin : receiver
        forever begin
            @(posedge i_clk);
            if (hold_cycles > 0) begin
                i_out_stall <= 1'b1;
                hold_cycles--;
            end else begin
                i_out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    // Watchdog: count cycles in which no transaction moves on any channel.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                    || (psel && penable && pready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
            if (quiet >= WATCHDOG_LIMIT) begin
                $display("heading_pid_motor_power verification failed");
                $finish;
            end
        end
    end

    // Offer one sample, idling first at the current rate; return once taken.
    // Valid stays high when the next sample follows without a gap.
    task automatic send_sample(input logic signed [DATA_W-1:0] heading,
                               input logic signed [DATA_W-1:0] rate);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_heading   <= heading;
        i_turn_rate <= rate;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drop valid, wait until every command has come back, then let the
    // pipeline empty before anything touches the registers.
    task automatic settle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (commands_owed != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Setup then access phase; bits above the register width carry noise.
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [APB_W-1:0] value,
                             input int width);
        logic [APB_W-1:0] keep;
        keep     = (APB_W'(1) << width) - 1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= ($urandom & ~keep) | (value & keep);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write all five registers, plus one write to an unmapped index.
    task automatic load_gains(input logic signed [DATA_W-1:0] target,
                              input logic signed [DATA_W-1:0] prop,
                              input logic signed [DATA_W-1:0] integ,
                              input logic signed [DATA_W-1:0] deriv,
                              input logic [TOL_W-1:0]         tol);
        cur_target = target;
        write_reg(REG_TARGET, APB_W'(target), DATA_W);
        write_reg(REG_PROP,   APB_W'(prop),   DATA_W);
        write_reg(REG_INTEG,  APB_W'(integ),  DATA_W);
        write_reg(REG_DERIV,  APB_W'(deriv),  DATA_W);
        write_reg(REG_TOL,    APB_W'(tol),    TOL_W);
        write_reg(REG_TOL + IDX_W'($urandom_range(1, 3)), $urandom, APB_W);
    endtask

    // Gains: rails, zero and random values, and small ones so the command lands between the clamps.
    function automatic logic signed [DATA_W-1:0] pick_gain();
        case ($urandom_range(6))
            0:       return S16_MIN;
            1:       return S16_MAX;
            2:       return '0;
            3:       return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(1024)) - 512);
        endcase
    endfunction

    function automatic logic [TOL_W-1:0] pick_tol();
        case ($urandom_range(5))
            0:       return '0;
            1:       return TOL_MAX;
            2:       return TOL_W'($urandom);
            default: return TOL_W'($urandom_range(16));
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_target();
        case ($urandom_range(4))
            0:       return S16_MIN;
            1:       return S16_MAX;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    // Headings: mostly close to the setpoint, some anywhere, some at the rails.
    function automatic logic signed [DATA_W-1:0] pick_heading();
        case ($urandom_range(19))
            0:             return S16_MIN;
            1:             return S16_MAX;
            2, 3, 4, 5, 6: return DATA_W'($urandom);
            default:       return DATA_W'(int'(cur_target) + int'($urandom_range(1200)) - 600);
        endcase
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_rate();
        case ($urandom_range(5))
            0:       return S16_MIN;
            1:       return S16_MAX;
            2, 3:    return DATA_W'($urandom);
            default: return DATA_W'(int'($urandom_range(800)) - 400);
        endcase
    endfunction

    initial begin : stimulus
        int p;
        int n;
        logic signed [DATA_W-1:0] h;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset gains: zero error sits in the deadband, a small error hits
        // the lower clamp, a heading at the rail drives the upper clamp.
        send_sample('0, '0);
        send_sample(DATA_W'(2), '0);
        send_sample(-DATA_W'(1), S16_MIN);
        send_sample(S16_MIN, S16_MAX);
        settle();

        // Setpoint at the top rail and heading at the bottom: the difference
        // saturates high; a full window drives the running sum to its top.
        load_gains(S16_MAX, S16_MIN, S16_MAX, S16_MIN, '0);
        for (n = 0; n < 10; n++) begin
            send_sample(S16_MIN, n[0] ? S16_MAX : S16_MIN);
        end
        settle();

        // Mirror case: saturate low, with the widest deadband; errors of
        // exactly the tolerance and zero error are mixed in.
        load_gains(S16_MIN, S16_MAX, S16_MIN, S16_MAX, TOL_MAX);
        for (n = 0; n < 8; n++) begin
            case (n)
                2:       h = -DATA_W'(1);
                4:       h = '0;
                5:       h = S16_MIN;
                7:       h = DATA_W'(1);
                default: h = S16_MAX;
            endcase
            send_sample(h, DATA_W'($urandom));
        end
        settle();

        // Tiny speed floors at power one either way; zero speed with error
        // outside the deadband still stops the motor.
        load_gains('0, '0, '0, DATA_W'(1), '0);
        send_sample('0, DATA_W'(3));
        send_sample('0, -DATA_W'(3));
        send_sample(DATA_W'(5), '0);
        send_sample('0, '0);

        // Random phases: each idling pattern twice, each with fresh registers.
        for (p = 0; p < PHASE_COUNT; p++) begin
            settle();
            load_gains(pick_target(), pick_gain(), pick_gain(), pick_gain(), pick_tol());
            case (p % 4)
                0: begin
                    idle_pct    = 0;
                    stall_pct   = 0;
                    hold_cycles = HOLD_OFF;
                end
                1: begin
                    idle_pct  = 80;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 80;
                end
                default: begin
                    idle_pct  = 18;
                    stall_pct = 18;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++) begin
                send_sample(pick_heading(), pick_rate());
            end
        end
        settle();

        if (mismatches == 0) begin
            $display("heading_pid_motor_power verification clean");
        end else begin
            $display("heading_pid_motor_power verification failed");
        end
        $finish;
    end

endmodule

// File: files.f
rtl/hpmp_pkg.sv
rtl/hpmp_regs.sv
rtl/hpmp_window.sv
rtl/hpmp_gain.sv
rtl/hpmp_power.sv
rtl/heading_pid_motor_power.sv
sim/heading_pid_motor_power_chk.sv
sim/heading_pid_motor_power_tb.sv
